>>> rtl/h264dpk_pkg.sv
// Shared types and constants for the H.264 RTP depacketizer.
package h264dpk_pkg;

    // NAL header fields
    localparam logic [7:0] NAL_TYPE_MASK  = 8'h1f;
    localparam logic [7:0] NAL_NRI_MASK   = 8'he0;
    localparam logic [7:0] FU_START_BIT   = 8'h80;
    localparam logic [7:0] FU_END_BIT     = 8'h40;

    // NAL unit types with special handling
    localparam logic [4:0] NAL_SINGLE_MIN = 5'd1;
    localparam logic [4:0] NAL_SINGLE_MAX = 5'd12;
    localparam logic [4:0] NAL_SPS        = 5'd7;
    localparam logic [4:0] NAL_PPS        = 5'd8;
    localparam logic [4:0] NAL_STAP_A     = 5'd24;
    localparam logic [4:0] NAL_FU_A       = 5'd28;

    // Result burst lengths
    localparam logic [2:0] BURST_START_LONG  = 3'd5;
    localparam logic [2:0] BURST_START_SHORT = 3'd4;
    localparam logic [2:0] BURST_ONE         = 3'd1;
    localparam logic [2:0] BURST_NONE        = 3'd0;

    // Input request
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        packet_first;
        logic        packet_last;
        logic        marker;
        logic [31:0] rtp_timestamp;
    } h264dpk_in_t;

    // Result request
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        frame_end;
        logic        frame_abort;
        logic [31:0] frame_timestamp;
    } h264dpk_out_t;

    // Results caused by one input request, in compact form
    typedef struct packed {
        logic [2:0]  count;       // number of results, 0 to 5
        logic        is_start;    // start code plus header byte
        logic        four;        // four-byte start code
        logic [7:0]  data;        // header byte or body byte
        logic        byte_valid;  // single result carries a byte
        logic        abort;       // single result is a frame abort
        logic        frame_end;   // last result closes the frame
        logic [31:0] ts;          // frame timestamp
    } h264dpk_burst_t;

endpackage

>>> rtl/h264_rtp_depacketizer_unit.sv
// Top level of the H.264 RTP depacketizer producing an Annex B byte stream.
//
//  channel  | ports                          | carries
//  ---------+--------------------------------+------------------------------------
//  input    | s_valid s_ready s_payload      | payload byte, packet flags, timestamp
//  result   | m_valid m_ready m_payload      | stream byte, frame end/abort, timestamp
//
// A request that yields zero or one result is taken every cycle while m_ready is high.
// A request that opens a NAL unit yields four or five results (start code plus
// header), one per cycle while m_ready is high, so the input waits behind it.
// The result holding register sets the pace: the next request enters in the
// cycle the last result of the current burst is taken.
// Reset (aresetn low, synchronous) closes any frame and empties the result stage.
module h264_rtp_depacketizer_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  h264dpk_pkg::h264dpk_in_t  s_payload,
    output logic                      m_valid,
    input  logic                      m_ready,
    output h264dpk_pkg::h264dpk_out_t m_payload
);
    import h264dpk_pkg::*;

    h264dpk_burst_t burst;
    logic           s_accept;

    assign s_accept = s_valid && s_ready;

    h264dpk_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .s_accept  (s_accept),
        .burst     (burst)
    );

    h264dpk_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .burst     (burst),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

>>> rtl/h264dpk_parse.sv
// Payload parser: packet and NAL state, turns each request into a result burst.
module h264dpk_parse (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  h264dpk_pkg::h264dpk_in_t    s_payload,
    input  logic                        s_accept,
    output h264dpk_pkg::h264dpk_burst_t burst
);
    import h264dpk_pkg::*;

    typedef enum logic [8:0] {
        PH_WAIT      = 9'b000000001,
        PH_SINGLE    = 9'b000000010,
        PH_STAP_HI   = 9'b000000100,
        PH_STAP_LO   = 9'b000001000,
        PH_STAP_NAL  = 9'b000010000,
        PH_STAP_BODY = 9'b000100000,
        PH_FU_HDR    = 9'b001000000,
        PH_FU_BODY   = 9'b010000000,
        PH_SKIP      = 9'b100000000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        in_frame_reg, in_frame_next;
    logic        first_nal_done_reg, first_nal_done_next;
    logic        fu_active_reg, fu_active_next;
    logic [15:0] unit_left_reg, unit_left_next;
    logic [7:0]  len_high_reg, len_high_next;
    logic [2:0]  fu_ind_reg, fu_ind_next;
    logic [31:0] frame_ts_reg, frame_ts_next;

    logic [7:0]  b;
    logic [4:0]  hdr_type;
    logic [15:0] unit_dec;
    logic        live;
    logic        first_nal_base;
    logic        nal_go;
    logic [7:0]  nal_hdr;
    logic        param_set;
    logic        four;
    logic        single_go;
    logic        abort_go;

    assign b        = s_payload.payload_byte;
    assign hdr_type = 5'(b & NAL_TYPE_MASK);
    assign unit_dec = unit_left_reg - 16'd1;

    // Next state and result burst for the request at the input
    always_comb begin
        phase_next          = phase_reg;
        in_frame_next       = in_frame_reg;
        fu_active_next      = fu_active_reg;
        unit_left_next      = unit_left_reg;
        len_high_next       = len_high_reg;
        fu_ind_next         = fu_ind_reg;
        frame_ts_next       = frame_ts_reg;
        first_nal_base      = first_nal_done_reg;
        live                = 1'b0;
        nal_go              = 1'b0;
        nal_hdr             = b;
        single_go           = 1'b0;
        abort_go            = 1'b0;
        burst               = '0;

        if (s_payload.packet_first) begin
            // Open a packet, and a frame if none is open
            live = 1'b1;
            if (!in_frame_reg) begin
                in_frame_next  = 1'b1;
                frame_ts_next  = s_payload.rtp_timestamp;
                first_nal_base = 1'b0;
            end
            unit_left_next = '0;
            if (fu_active_reg) begin
                phase_next = PH_FU_HDR;
            end else if (hdr_type >= NAL_SINGLE_MIN && hdr_type <= NAL_SINGLE_MAX) begin
                nal_go     = 1'b1;
                phase_next = PH_SINGLE;
            end else if (hdr_type == NAL_STAP_A) begin
                phase_next = PH_STAP_HI;
            end else if (hdr_type == NAL_FU_A) begin
                fu_ind_next = 3'((b & NAL_NRI_MASK) >> 5);
                phase_next  = PH_FU_HDR;
            end else begin
                phase_next = PH_SKIP;
            end
        end else if (phase_reg != PH_WAIT) begin
            // Continue the open packet; orphan bytes fall through untouched
            live = 1'b1;
            unique case (phase_reg)
                PH_SINGLE, PH_FU_BODY: begin
                    single_go = 1'b1;
                end
                PH_STAP_HI: begin
                    len_high_next = b;
                    phase_next    = PH_STAP_LO;
                end
                PH_STAP_LO: begin
                    unit_left_next = {len_high_reg, b};
                    phase_next     = ({len_high_reg, b} != 16'd0) ? PH_STAP_NAL : PH_STAP_HI;
                end
                PH_STAP_NAL: begin
                    nal_go         = 1'b1;
                    unit_left_next = unit_dec;
                    phase_next     = (unit_dec != 16'd0) ? PH_STAP_BODY : PH_STAP_HI;
                end
                PH_STAP_BODY: begin
                    single_go      = 1'b1;
                    unit_left_next = unit_dec;
                    if (unit_dec == 16'd0) begin
                        phase_next = PH_STAP_HI;
                    end
                end
                PH_FU_HDR: begin
                    if (fu_active_reg) begin
                        if ((b & FU_END_BIT) != 8'd0) begin
                            fu_active_next = 1'b0;
                        end
                        phase_next = PH_FU_BODY;
                    end else if ((b & FU_START_BIT) == 8'd0) begin
                        // Fragment start missing: drop the frame
                        abort_go       = 1'b1;
                        in_frame_next  = 1'b0;
                        fu_active_next = 1'b0;
                        phase_next     = PH_SKIP;
                    end else begin
                        nal_go         = 1'b1;
                        nal_hdr        = {fu_ind_reg, hdr_type};
                        fu_active_next = ((b & FU_END_BIT) == 8'd0);
                        phase_next     = PH_FU_BODY;
                    end
                end
                PH_SKIP, PH_WAIT: begin
                end
                default: begin
                end
            endcase
        end

        // Start code length; SPS, PPS and the frame's first NAL get the long form
        param_set = (nal_hdr[4:0] == NAL_SPS) || (nal_hdr[4:0] == NAL_PPS);
        four      = param_set || !first_nal_base;
        first_nal_done_next = nal_go ? (first_nal_base || !param_set) : first_nal_base;

        // Assemble the burst
        burst.is_start   = nal_go;
        burst.four       = four;
        burst.data       = nal_go ? nal_hdr : (single_go ? b : 8'd0);
        burst.byte_valid = single_go;
        burst.abort      = abort_go;
        burst.ts         = 32'd0;
        if (nal_go) begin
            burst.count = four ? BURST_START_LONG : BURST_START_SHORT;
        end else if (single_go || abort_go) begin
            burst.count = BURST_ONE;
        end else begin
            burst.count = BURST_NONE;
        end

        // Close the packet, and the frame on a marker
        if (live && s_payload.packet_last) begin
            if (!abort_go && s_payload.marker && in_frame_next) begin
                burst.frame_end = 1'b1;
                burst.ts        = frame_ts_next;
                if (burst.count == BURST_NONE) begin
                    burst.count = BURST_ONE;
                end
                in_frame_next  = 1'b0;
                fu_active_next = 1'b0;
            end
            phase_next     = PH_WAIT;
            unit_left_next = '0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_WAIT;
            in_frame_reg       <= 1'b0;
            first_nal_done_reg <= 1'b0;
            fu_active_reg      <= 1'b0;
        end else if (s_accept) begin
            phase_reg          <= phase_next;
            in_frame_reg       <= in_frame_next;
            first_nal_done_reg <= first_nal_done_next;
            fu_active_reg      <= fu_active_next;
        end
    end

    // Length, header and timestamp holding registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            unit_left_reg <= unit_left_next;
            len_high_reg  <= len_high_next;
            fu_ind_reg    <= fu_ind_next;
            frame_ts_reg  <= frame_ts_next;
        end
    end

endmodule

>>> rtl/h264dpk_emit.sv
// Result emitter: holds one burst and sends its results one per cycle while m_ready is high.
module h264dpk_emit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  h264dpk_pkg::h264dpk_burst_t burst,
    input  logic                        s_valid,
    output logic                        s_ready,
    output logic                        m_valid,
    input  logic                        m_ready,
    output h264dpk_pkg::h264dpk_out_t   m_payload
);
    import h264dpk_pkg::*;

    h264dpk_burst_t burst_reg;
    logic [2:0]     count_reg;
    logic [2:0]     idx_reg;
    logic           busy;
    logic           last_beat;
    logic           take;
    logic [2:0]     zero_len;

    assign busy      = (count_reg != BURST_NONE);
    assign last_beat = (idx_reg == count_reg - 3'd1);
    assign s_ready   = !busy || (m_ready && last_beat);
    assign take      = s_valid && s_ready;
    assign m_valid   = busy;
    assign zero_len  = burst_reg.four ? 3'd3 : 3'd2;

    // Hold the burst and step through its results; empty after the last one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= BURST_NONE;
            idx_reg   <= '0;
        end else if (take) begin
            count_reg <= burst.count;
            idx_reg   <= '0;
        end else if (busy && m_ready) begin
            if (last_beat) begin
                count_reg <= BURST_NONE;
                idx_reg   <= '0;
            end else begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            burst_reg <= burst;
        end
    end

    // Select the current result
    always_comb begin
        m_payload = '0;
        if (burst_reg.is_start) begin
            m_payload.byte_valid = 1'b1;
            if (idx_reg < zero_len) begin
                m_payload.out_byte = 8'h00;
            end else if (idx_reg == zero_len) begin
                m_payload.out_byte = 8'h01;
            end else begin
                m_payload.out_byte = burst_reg.data;
            end
        end else begin
            m_payload.byte_valid  = burst_reg.byte_valid;
            m_payload.out_byte    = burst_reg.data;
            m_payload.frame_abort = burst_reg.abort;
        end
        if (burst_reg.frame_end && last_beat) begin
            m_payload.frame_end       = 1'b1;
            m_payload.frame_timestamp = burst_reg.ts;
        end
    end

endmodule

>>> rtl/h264dpk_checker.sv
// Port-level checker for the depacketizer, bound to the top level.
module h264dpk_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input h264dpk_pkg::h264dpk_in_t  s_payload,
    input logic                      m_valid,
    input logic                      m_ready,
    input h264dpk_pkg::h264dpk_out_t m_payload
);
    import h264dpk_pkg::*;

    // Stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    // Abort carries no byte and no frame end
    a_abort_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.frame_abort |-> !m_payload.byte_valid && !m_payload.frame_end)
        else $error("abort result carries byte or frame end");

    // Timestamp shows only with frame end
    a_ts_only_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload.frame_end |-> m_payload.frame_timestamp == 32'd0)
        else $error("timestamp without frame end");

    // Result without a byte carries zero
    a_empty_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload.byte_valid |-> m_payload.out_byte == 8'd0)
        else $error("nonzero byte on empty result");

    // Reset empties the result stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

endmodule

bind h264_rtp_depacketizer_unit h264dpk_checker u_checker (.*);

>>> tb/tb_h264_rtp_depacketizer_unit.sv
// Self-checking testbench for the H.264 RTP depacketizer: packet stimulus, stream prediction, checking.
`timescale 1ns / 1ps

module tb_h264_rtp_depacketizer_unit;
    import h264dpk_pkg::*;

    // Parser phases of the stream predictor
    typedef enum logic [3:0] {
        ST_WAIT_PKT,
        ST_SINGLE,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_UNIT_HDR,
        ST_UNIT_BODY,
        ST_FU_HDR,
        ST_FU_BODY,
        ST_DROP
    } parse_phase_e;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    h264dpk_in_t  s_payload = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    h264dpk_out_t m_payload;

    // Requests waiting to be driven, bytes of the packet under construction
    h264dpk_in_t  pending_req[$];
    logic [7:0]   byte_q[$];
    logic [31:0]  pkt_ts = '0;
    int           items_queued = 0;

    // Stream bytes and frame marks still owed by the block
    h264dpk_out_t stream_expected[$];
    h264dpk_out_t step_res [0:4];
    int           step_n;
    int           mismatches = 0;

    // Predictor state
    logic         pr_in_frame = 1'b0;
    logic         pr_first_nal_done = 1'b0;
    parse_phase_e pr_phase = ST_WAIT_PKT;
    logic         pr_fu_active = 1'b0;
    logic [15:0]  pr_unit_left = '0;
    logic [7:0]   pr_len_hi = '0;
    logic [2:0]   pr_nri = '0;
    logic [31:0]  pr_frame_ts = '0;

    // Handshake flags sampled at the rising edge, pacing state
    logic         s_fire = 1'b0;
    logic         m_fire = 1'b0;
    int           s_wait = 0;
    int           s_calm = 0;
    int           m_wait = 0;
    int           m_calm = 0;
    int           hold_requests = 0;
    int           holds_done = 0;

    h264_rtp_depacketizer_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 40) begin
            $display("%0t ns: MISMATCH %s", $time, msg);
        end
    endtask

    // Append one stream byte to the results of the current request
    function automatic void add_stream_byte(logic [7:0] b);
        h264dpk_out_t r;
        r = '0;
        r.out_byte = b;
        r.byte_valid = 1'b1;
        step_res[step_n] = r;
        step_n++;
    endfunction

    // Start code (long for SPS, PPS and a frame's first NAL) followed by the header
    function automatic void add_nal_start(logic [7:0] hdr);
        logic [4:0] t;
        logic       four;
        t = hdr[4:0];
        four = (t == NAL_SPS) || (t == NAL_PPS);
        if (!four && !pr_first_nal_done) begin
            pr_first_nal_done = 1'b1;
            four = 1'b1;
        end
        add_stream_byte(8'h00);
        add_stream_byte(8'h00);
        if (four) begin
            add_stream_byte(8'h00);
        end
        add_stream_byte(8'h01);
        add_stream_byte(hdr);
    endfunction

    // Advance the predictor by one accepted request and queue what it yields
    function automatic void predict_stream(h264dpk_in_t req);
        logic [7:0] b;
        logic [4:0] t;
        logic       aborted;
        int         i;
        b = req.payload_byte;
        t = b[4:0];
        aborted = 1'b0;
        step_n = 0;
        if (req.packet_first) begin
            if (!pr_in_frame) begin
                pr_in_frame = 1'b1;
                pr_frame_ts = req.rtp_timestamp;
                pr_first_nal_done = 1'b0;
            end
            pr_unit_left = '0;
            if (pr_fu_active) begin
                pr_phase = ST_FU_HDR;
            end else if (t >= NAL_SINGLE_MIN && t <= NAL_SINGLE_MAX) begin
                add_nal_start(b);
                pr_phase = ST_SINGLE;
            end else if (t == NAL_STAP_A) begin
                pr_phase = ST_LEN_HI;
            end else if (t == NAL_FU_A) begin
                pr_nri = b[7:5];
                pr_phase = ST_FU_HDR;
            end else begin
                pr_phase = ST_DROP;
            end
        end else begin
            // drop orphan bytes outright, flags included
            if (pr_phase == ST_WAIT_PKT) begin
                return;
            end
            case (pr_phase)
                ST_SINGLE, ST_FU_BODY: begin
                    add_stream_byte(b);
                end
                ST_LEN_HI: begin
                    pr_len_hi = b;
                    pr_phase = ST_LEN_LO;
                end
                ST_LEN_LO: begin
                    pr_unit_left = {pr_len_hi, b};
                    pr_phase = (pr_unit_left != 0) ? ST_UNIT_HDR : ST_LEN_HI;
                end
                ST_UNIT_HDR: begin
                    add_nal_start(b);
                    pr_unit_left = pr_unit_left - 16'd1;
                    pr_phase = (pr_unit_left != 0) ? ST_UNIT_BODY : ST_LEN_HI;
                end
                ST_UNIT_BODY: begin
                    add_stream_byte(b);
                    pr_unit_left = pr_unit_left - 16'd1;
                    if (pr_unit_left == 0) begin
                        pr_phase = ST_LEN_HI;
                    end
                end
                ST_FU_HDR: begin
                    if (pr_fu_active) begin
                        if ((b & FU_END_BIT) != 0) begin
                            pr_fu_active = 1'b0;
                        end
                        pr_phase = ST_FU_BODY;
                    end else if ((b & FU_START_BIT) == 0) begin
                        // fragment start without S bit: abort the frame
                        step_res[0] = '0;
                        step_res[0].frame_abort = 1'b1;
                        step_n = 1;
                        pr_in_frame = 1'b0;
                        pr_fu_active = 1'b0;
                        pr_phase = ST_DROP;
                        aborted = 1'b1;
                    end else begin
                        add_nal_start({pr_nri, b[4:0]});
                        pr_fu_active = ((b & FU_END_BIT) == 0);
                        pr_phase = ST_FU_BODY;
                    end
                end
                default: begin
                end
            endcase
        end
        // close the frame on a marked packet end
        if (req.packet_last) begin
            if (!aborted && req.marker && pr_in_frame) begin
                if (step_n == 0) begin
                    step_res[0] = '0;
                    step_n = 1;
                end
                step_res[step_n - 1].frame_end = 1'b1;
                step_res[step_n - 1].frame_timestamp = pr_frame_ts;
                pr_in_frame = 1'b0;
                pr_fu_active = 1'b0;
            end
            pr_phase = ST_WAIT_PKT;
            pr_unit_left = '0;
        end
        for (i = 0; i < step_n; i++) begin
            stream_expected.push_back(step_res[i]);
        end
    endfunction

    // Sample both handshakes, predict accepted requests, check taken results
    always @(posedge aclk) begin : stream_monitor
        h264dpk_out_t want;
        s_fire = aresetn && s_valid && s_ready;
        m_fire = aresetn && m_valid && m_ready;
        if (s_fire) begin
            predict_stream(s_payload);
        end
        if (m_fire) begin
            if (stream_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", m_payload));
            end else begin
                want = stream_expected.pop_front();
                if (m_payload.out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %h, want %h",
                        m_payload.out_byte, want.out_byte));
                if (m_payload.byte_valid !== want.byte_valid)
                    report_mismatch($sformatf("byte_valid %b, want %b",
                        m_payload.byte_valid, want.byte_valid));
                if (m_payload.frame_end !== want.frame_end)
                    report_mismatch($sformatf("frame_end %b, want %b",
                        m_payload.frame_end, want.frame_end));
                if (m_payload.frame_abort !== want.frame_abort)
                    report_mismatch($sformatf("frame_abort %b, want %b",
                        m_payload.frame_abort, want.frame_abort));
                if (m_payload.frame_timestamp !== want.frame_timestamp)
                    report_mismatch($sformatf("frame_timestamp %h, want %h",
                        m_payload.frame_timestamp, want.frame_timestamp));
            end
        end
    end

    // Drive requests from the pending queue with a random gap after each
    always @(negedge aclk) begin : request_driver
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (s_wait > 0) begin
                s_wait--;
                s_valid <= 1'b0;
            end else if (pending_req.size() != 0) begin
                s_payload <= pending_req.pop_front();
                s_valid <= 1'b1;
                if (s_calm > 0) begin
                    s_calm--;
                    s_wait = 0;
                end else begin
                    s_wait = $urandom_range(0, 10);
                    if ($urandom_range(0, 15) == 0) begin
                        s_calm = $urandom_range(10, 40);
                    end
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Pace m_ready: random stall after each taken result, long hold on request
    always @(negedge aclk) begin : result_pacer
        if (hold_requests != holds_done) begin
            holds_done = hold_requests;
            m_wait = 250;
        end else if (m_fire) begin
            if (m_calm > 0) begin
                m_calm--;
                m_wait = 0;
            end else begin
                m_wait = $urandom_range(0, 10);
                if ($urandom_range(0, 15) == 0) begin
                    m_calm = $urandom_range(10, 40);
                end
            end
        end
        if (m_wait > 0) begin
            m_wait--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic queue_req(logic [7:0] b, logic is_first, logic is_last, logic mark);
        h264dpk_in_t req;
        req.payload_byte = b;
        req.packet_first = is_first;
        req.packet_last = is_last;
        req.marker = mark;
        req.rtp_timestamp = pkt_ts;
        pending_req.push_back(req);
    endtask

    // Turn the bytes in byte_q into one packet; a cut packet has no last byte
    task automatic send_packet(logic mark, logic cut);
        int i;
        for (i = 0; i < byte_q.size(); i++) begin
            queue_req(byte_q[i], i == 0, (i == byte_q.size() - 1) && !cut, mark);
            items_queued++;
        end
        byte_q.delete();
        if (mark) begin
            pkt_ts = $urandom;
        end
    endtask

    task automatic add_body(int n);
        repeat (n) byte_q.push_back(8'($urandom));
    endtask

    // Build one random packet, fragment sequence or burst of noise
    task automatic random_packet();
        int         kind;
        int         n;
        int         k;
        logic       mark;
        logic [7:0] fu_ind;
        logic [4:0] t5;
        kind = $urandom_range(0, 99);
        mark = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 7) == 0) begin
            pkt_ts = $urandom;
        end
        if (kind < 25) begin
            byte_q.push_back({3'($urandom), 5'($urandom_range(1, 12))});
            add_body($urandom_range(0, 6));
            send_packet(mark, 1'b0);
        end else if (kind < 45) begin
            // aggregation packet, zero lengths and oversized units included
            byte_q.push_back({3'($urandom), NAL_STAP_A});
            n = $urandom_range(1, 3);
            repeat (n) begin
                k = $urandom_range(0, 5);
                byte_q.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00);
                byte_q.push_back(8'(k));
                if (k > 0) begin
                    byte_q.push_back(8'($urandom));
                    add_body(k - 1);
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    if (byte_q.size() > 1) begin
                        void'(byte_q.pop_back());
                    end
                end
            end
            send_packet(mark, 1'b0);
        end else if (kind < 75) begin
            // fragment sequence; now and then a marker lands mid-fragment
            fu_ind = {3'($urandom), NAL_FU_A};
            t5 = 5'($urandom);
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) begin
                byte_q.push_back((k > 0 && $urandom_range(0, 9) == 0) ? 8'($urandom) : fu_ind);
                byte_q.push_back({(k == 0), (k == n - 1), 1'($urandom), t5});
                add_body($urandom_range(0, 4));
                send_packet((k == n - 1) ? mark : ($urandom_range(0, 7) == 0), 1'b0);
            end
        end else if (kind < 80) begin
            do begin
                t5 = 5'($urandom);
            end while ((t5 >= NAL_SINGLE_MIN && t5 <= NAL_SINGLE_MAX) ||
                       t5 == NAL_STAP_A || t5 == NAL_FU_A);
            byte_q.push_back({3'($urandom), t5});
            add_body($urandom_range(0, 4));
            send_packet(mark, 1'b0);
        end else if (kind < 85) begin
            byte_q.push_back({3'($urandom), NAL_FU_A});
            byte_q.push_back({1'b0, 7'($urandom)});
            add_body($urandom_range(0, 3));
            send_packet(mark, 1'b0);
        end else if (kind < 88) begin
            byte_q.push_back({3'($urandom), NAL_FU_A});
            send_packet(mark, 1'b0);
        end else if (kind < 92) begin
            // packet cut short by the next packet start
            byte_q.push_back({3'($urandom), 5'($urandom_range(1, 12))});
            add_body($urandom_range(1, 4));
            send_packet(mark, 1'b1);
        end else if (kind < 96) begin
            repeat ($urandom_range(1, 3)) begin
                queue_req(8'($urandom), 1'b0, 1'($urandom), 1'($urandom));
            end
        end else begin
            repeat ($urandom_range(1, 6)) begin
                pkt_ts = $urandom;
                queue_req(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
                items_queued++;
            end
        end
    endtask

    // Hold the sender until every queued request is in and every result is out
    task automatic wait_drained();
        int cycles;
        cycles = 0;
        while ((pending_req.size() != 0 || s_valid || stream_expected.size() != 0) &&
               cycles < 30000) begin
            @(posedge aclk);
            cycles++;
        end
        if (stream_expected.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", stream_expected.size()));
        end
        repeat (20) @(posedge aclk);
    endtask

    initial begin : stimulus
        int target;
        int ph;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // SPS gets a long start code but leaves the first-NAL rule armed
        pkt_ts = '0;
        byte_q = '{{3'b011, NAL_SPS}, 8'h42};
        send_packet(1'b0, 1'b0);
        // first slice of the frame, marker on an all-ones byte
        byte_q = '{{3'b010, NAL_SINGLE_MIN}, 8'hff};
        send_packet(1'b1, 1'b0);
        // orphan byte with marker and last set
        queue_req(8'h55, 1'b0, 1'b1, 1'b1);
        // aggregation: zero length skipped, PPS unit, last unit truncated
        pkt_ts = 32'hffff_ffff;
        byte_q = '{{3'b011, NAL_STAP_A}, 8'h00, 8'h00, 8'h00, 8'h02,
                   {3'b011, NAL_PPS}, 8'haa, 8'h00, 8'h05,
                   {3'b011, NAL_SINGLE_MAX}, 8'h11};
        send_packet(1'b1, 1'b0);
        // fragment start without S bit aborts, marker ignored
        pkt_ts = 32'h1234_5678;
        byte_q = '{{3'b011, NAL_FU_A}, 8'h05, 8'h22};
        send_packet(1'b1, 1'b0);
        // fragment packet ending before its header: frame end with no byte
        pkt_ts = 32'h8000_0001;
        byte_q = '{{3'b010, NAL_FU_A}};
        send_packet(1'b1, 1'b0);
        // unspecified type 0, then reserved type 31 (all bits set) closing the frame
        pkt_ts = 32'h0000_00ff;
        byte_q = '{8'h00, 8'h12};
        send_packet(1'b0, 1'b0);
        byte_q = '{8'hff};
        send_packet(1'b1, 1'b0);
        wait_drained();

        // random phases; the middle one holds the result side off for a while
        for (ph = 0; ph < 3; ph++) begin
            target = items_queued + 80;
            while (items_queued < target) begin
                random_packet();
            end
            if (ph == 1) begin
                hold_requests++;
            end
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
